// ----- design/cgf_pkg.sv -----
package cgf_pkg;

  localparam int DIV_STEPS  = 77;
  localparam int Q_W        = 77;
  localparam int S_W        = 66;
  localparam int NUM_W      = 96;
  localparam int FM_W       = 78;
  localparam int U_W        = 31;
  localparam int SQRT_STEPS = 31;
  localparam int SQRT_IN_W  = 61;
  localparam int SQ_REM_W   = 32;
  localparam int CHUNK_W    = 26;
  localparam int PP_W       = CHUNK_W + U_W;
  localparam int MAG_W      = 79;
  localparam int FORCE_W    = 48;
  localparam int SCALE_STAGES = 3;
  localparam int SB_LEN     = DIV_STEPS + SQRT_STEPS + SCALE_STAGES;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CENTRAL_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRAL_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRAL_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRAL_M   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_K   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRAL_ID  = 3'd5;

  localparam logic [MAG_W-1:0] SAT_POS_M = MAG_W'(48'h7FFF_FFFF_FFFF);
  localparam logic [MAG_W-1:0] SAT_NEG_M = MAG_W'(48'h8000_0000_0000);
  localparam logic [FM_W-1:0]  FM_CLAMP  = {1'b1, {(FM_W-1){1'b0}}};

  typedef struct packed {
    logic [15:0] id;
    logic        skip;
    logic        coinc;
    logic        ovf;
    logic [2:0]  neg;
  } sideband_t;

  function automatic logic [FORCE_W-1:0] sat_force(input logic [MAG_W-1:0] mag,
                                                   input logic neg);
    logic [FORCE_W-1:0] m;
    if (neg) begin
      m = (mag > SAT_NEG_M) ? SAT_NEG_M[FORCE_W-1:0] : mag[FORCE_W-1:0];
      return FORCE_W'(~m + 1'b1);
    end else begin
      m = (mag > SAT_POS_M) ? SAT_POS_M[FORCE_W-1:0] : mag[FORCE_W-1:0];
      return m;
    end
  endfunction

endpackage

// ----- design/cgf_divider.sv -----
module cgf_divider
  import cgf_pkg::*;
(
  input  logic           clk,
  input  logic           en,
  input  logic [S_W-1:0] rem_in,
  input  logic [Q_W-1:0] low_in,
  input  logic [S_W-1:0] dvs_in,
  output logic [Q_W-1:0] quo
);

  logic [S_W-1:0] rem_r [DIV_STEPS];
  logic [Q_W-1:0] low_r [DIV_STEPS];
  logic [Q_W-1:0] q_r   [DIV_STEPS];
  logic [S_W-1:0] dvs_r [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [S_W-1:0] rem_j;
    logic [Q_W-1:0] low_j;
    logic [Q_W-1:0] q_j;
    logic [S_W-1:0] dvs_j;
    logic [S_W:0]   shifted;
    logic [S_W:0]   diff;
    logic           ge;

    if (j == 0) begin : g_first
      assign rem_j = rem_in;
      assign low_j = low_in;
      assign q_j   = '0;
      assign dvs_j = dvs_in;
    end else begin : g_rest
      assign rem_j = rem_r[j-1];
      assign low_j = low_r[j-1];
      assign q_j   = q_r[j-1];
      assign dvs_j = dvs_r[j-1];
    end

    assign shifted = {rem_j, low_j[Q_W-1]};
    assign ge      = shifted >= {1'b0, dvs_j};
    assign diff    = shifted - {1'b0, dvs_j};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? diff[S_W-1:0] : shifted[S_W-1:0];
        low_r[j] <= {low_j[Q_W-2:0], 1'b0};
        q_r[j]   <= {q_j[Q_W-2:0], ge};
        dvs_r[j] <= dvs_j;
      end
    end
  end

  assign quo = q_r[DIV_STEPS-1];

endmodule

// ----- design/cgf_isqrt.sv -----
module cgf_isqrt
  import cgf_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [SQRT_IN_W-1:0] x,
  output logic [U_W-1:0]       root
);

  logic [SQ_REM_W-1:0]    rem_r [SQRT_STEPS];
  logic [U_W-1:0]         res_r [SQRT_STEPS];
  logic [2*U_W-1:0]       xs_r  [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    logic [SQ_REM_W-1:0] rem_j;
    logic [U_W-1:0]      res_j;
    logic [2*U_W-1:0]    xs_j;
    logic [SQ_REM_W+1:0] r2;
    logic [SQ_REM_W+1:0] trial;
    logic [SQ_REM_W+1:0] diff;
    logic                ge;

    if (j == 0) begin : g_first
      assign rem_j = '0;
      assign res_j = '0;
      assign xs_j  = {1'b0, x};
    end else begin : g_rest
      assign rem_j = rem_r[j-1];
      assign res_j = res_r[j-1];
      assign xs_j  = xs_r[j-1];
    end

    assign r2    = {rem_j, xs_j[2*U_W-1 -: 2]};
    assign trial = {1'b0, res_j, 2'b01};
    assign ge    = r2 >= trial;
    assign diff  = r2 - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? diff[SQ_REM_W-1:0] : r2[SQ_REM_W-1:0];
        res_r[j] <= {res_j[U_W-2:0], ge};
        xs_r[j]  <= {xs_j[2*U_W-3:0], 2'b00};
      end
    end
  end

  assign root = res_r[SQRT_STEPS-1];

endmodule

// ----- design/cgf_scale.sv -----
module cgf_scale
  import cgf_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [FM_W-1:0]  fm,
  input  logic [U_W-1:0]   u,
  output logic [MAG_W-1:0] mag
);

  logic [PP_W-1:0]           p0;
  logic [PP_W-1:0]           p1;
  logic [PP_W-1:0]           p2;
  logic [PP_W-1:0]           p2_d;
  logic [PP_W+CHUNK_W-1:0]   acc;
  logic [PP_W+2*CHUNK_W-1:0] total;

  assign total = {{CHUNK_W{1'b0}}, acc} + {p2_d, {(2*CHUNK_W){1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      p0   <= PP_W'(fm[CHUNK_W-1:0] * u);
      p1   <= PP_W'(fm[2*CHUNK_W-1:CHUNK_W] * u);
      p2   <= PP_W'(fm[3*CHUNK_W-1:2*CHUNK_W] * u);
      acc  <= {{CHUNK_W{1'b0}}, p0} + {p1, {CHUNK_W{1'b0}}};
      p2_d <= p2;
      mag  <= total[PP_W+2*CHUNK_W-1 -: MAG_W];
    end
  end

endmodule

// ----- design/central_gravity_force.sv -----
// throughput: one transaction per cycle when m_axis is not stalled, set by the
// 77-step divider and 31-step square root pipelines which each take a new
// operand every cycle
// a stall on m_axis freezes the whole pipeline; nothing is lost or repeated
// reset: synchronous, clears all valid bits and loads the register defaults
module central_gravity_force
  import cgf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [143:0]         s_axis_tdata,  // body_id, body_mass, pos_x, pos_y, pos_z
  input  logic                 s_axis_tuser,  // clump_member
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [159:0]         m_axis_tdata,  // out_id, force_x, force_y, force_z
  output logic [1:0]           m_axis_tuser,  // applied, coincident
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [31:0] central_x;
  logic [31:0] central_y;
  logic [31:0] central_z;
  logic [31:0] central_mass;
  logic [31:0] gravity_constant;
  logic [15:0] central_id;

  logic adv;
  logic v1, v2, v3, v4;
  logic vd [SB_LEN];

  // stage 1
  logic [15:0] id1;
  logic [31:0] mass1;
  logic        skip1;
  logic [2:0]  neg1;
  logic [31:0] dabs1 [3];
  logic [63:0] km1;
  // stage 2
  logic [15:0] id2;
  logic        skip2;
  logic [2:0]  neg2;
  logic [63:0] sq2 [3];
  logic [63:0] nlo2;
  logic [63:0] nhi2;
  // stage 3
  logic [15:0]      id3;
  logic             skip3;
  logic [2:0]       neg3;
  logic [63:0]      sq3 [3];
  logic [S_W-1:0]   s3;
  logic [NUM_W-1:0] num3;
  // stage 4
  logic [S_W-1:0] rem4 [4];
  logic [Q_W-1:0] low4 [4];
  logic [S_W-1:0] s4;
  sideband_t      sb4;

  sideband_t      sb [SB_LEN];
  logic [FM_W-1:0] fmd [SQRT_STEPS];
  logic [Q_W-1:0]  quo [4];
  logic [U_W-1:0]  uvec [3];
  logic [MAG_W-1:0] mag [3];
  logic [FM_W-1:0] fm_c;
  logic            ovf3;

  logic [15:0]         out_id;
  logic [FORCE_W-1:0]  force_x, force_y, force_z;
  logic                applied, coincident;
  logic [31:0]         pos [3];
  logic [31:0]         cpos [3];

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tdata  = {force_z, force_y, force_x, out_id};
  assign m_axis_tuser  = {coincident, applied};

  assign pos[0]  = s_axis_tdata[79:48];
  assign pos[1]  = s_axis_tdata[111:80];
  assign pos[2]  = s_axis_tdata[143:112];
  assign cpos[0] = central_x;
  assign cpos[1] = central_y;
  assign cpos[2] = central_z;

  assign ovf3 = {{(S_W-19){1'b0}}, num3[NUM_W-1:Q_W]} >= s3;
  assign fm_c = sb[DIV_STEPS-1].ovf ? FM_CLAMP : {1'b0, quo[3]};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      central_x        <= '0;
      central_y        <= '0;
      central_z        <= '0;
      central_mass     <= 32'd65536;
      gravity_constant <= 32'd65536;
      central_id       <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_CENTRAL_X:  central_x        <= cfg_data;
        REG_CENTRAL_Y:  central_y        <= cfg_data;
        REG_CENTRAL_Z:  central_z        <= cfg_data;
        REG_CENTRAL_M:  central_mass     <= cfg_data;
        REG_GRAVITY_K:  gravity_constant <= cfg_data;
        REG_CENTRAL_ID: central_id       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      for (int k = 0; k < SB_LEN; k++) vd[k] <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      vd[0] <= v4;
      for (int k = 1; k < SB_LEN; k++) vd[k] <= vd[k-1];
      m_axis_tvalid <= vd[SB_LEN-1];
    end
  end

  // front stages
  always_ff @(posedge clk) begin
    logic [32:0] d;
    if (adv) begin
      id1   <= s_axis_tdata[15:0];
      mass1 <= s_axis_tdata[47:16];
      skip1 <= s_axis_tuser || (s_axis_tdata[15:0] == central_id);
      km1   <= 64'(gravity_constant * central_mass);
      for (int i = 0; i < 3; i++) begin
        d = {cpos[i][31], cpos[i]} - {pos[i][31], pos[i]};
        neg1[i]  <= d[32];
        dabs1[i] <= d[32] ? 32'(-d) : d[31:0];
      end

      id2   <= id1;
      skip2 <= skip1;
      neg2  <= neg1;
      for (int i = 0; i < 3; i++) sq2[i] <= 64'(dabs1[i] * dabs1[i]);
      nlo2 <= 64'(km1[31:0] * mass1);
      nhi2 <= 64'(km1[63:32] * mass1);

      id3   <= id2;
      skip3 <= skip2;
      neg3  <= neg2;
      for (int i = 0; i < 3; i++) sq3[i] <= sq2[i];
      s3   <= S_W'(sq2[0]) + S_W'(sq2[1]) + S_W'(sq2[2]);
      num3 <= {32'd0, nlo2} + {nhi2, 32'd0};

      s4        <= s3;
      sb4.id    <= id3;
      sb4.skip  <= skip3;
      sb4.coinc <= (s3 == '0);
      sb4.ovf   <= ovf3;
      sb4.neg   <= neg3;
      rem4[3]   <= ovf3 ? '0 : S_W'(num3[NUM_W-1:Q_W]);
      low4[3]   <= num3[Q_W-1:0];
      for (int i = 0; i < 3; i++) begin
        rem4[i] <= S_W'(sq3[i][63:17]);
        low4[i] <= {sq3[i][16:0], 60'd0};
      end
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_div
    cgf_divider u_div (
      .clk    (clk),
      .en     (adv),
      .rem_in (rem4[i]),
      .low_in (low4[i]),
      .dvs_in (s4),
      .quo    (quo[i])
    );
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    cgf_isqrt u_isqrt (
      .clk  (clk),
      .en   (adv),
      .x    (quo[i][SQRT_IN_W-1:0]),
      .root (uvec[i])
    );
    cgf_scale u_scale (
      .clk (clk),
      .en  (adv),
      .fm  (fmd[SQRT_STEPS-1]),
      .u   (uvec[i]),
      .mag (mag[i])
    );
  end

  // sideband and force magnitude delay lines, output register
  always_ff @(posedge clk) begin
    sideband_t so;
    if (adv) begin
      sb[0] <= sb4;
      for (int k = 1; k < SB_LEN; k++) sb[k] <= sb[k-1];
      fmd[0] <= fm_c;
      for (int k = 1; k < SQRT_STEPS; k++) fmd[k] <= fmd[k-1];

      so = sb[SB_LEN-1];
      out_id <= so.id;
      if (so.skip) begin
        force_x    <= '0;
        force_y    <= '0;
        force_z    <= '0;
        applied    <= 1'b0;
        coincident <= 1'b0;
      end else if (so.coinc) begin
        force_x    <= '0;
        force_y    <= '0;
        force_z    <= '0;
        applied    <= 1'b1;
        coincident <= 1'b1;
      end else begin
        force_x    <= sat_force(mag[0], so.neg[0]);
        force_y    <= sat_force(mag[1], so.neg[1]);
        force_z    <= sat_force(mag[2], so.neg[2]);
        applied    <= 1'b1;
        coincident <= 1'b0;
      end
    end
  end

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[159:16] == '0 && !m_axis_tuser[1]))
    else $error("skipped body carries a force");

  a_coinc_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[159:16] == '0 && m_axis_tuser[0]))
    else $error("coincident body carries a force");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_accept_tracked: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> v1)
    else $error("accepted transaction lost at entry");

endmodule

// ----- tb/tb_central_gravity_force.sv -----
`timescale 1ns / 1ps
module tb_central_gravity_force;
  import cgf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [15:0] id;
    logic [47:0] fx, fy, fz;
    logic        applied;
    logic        coinc;
  } force_t;

  typedef struct {
    logic [15:0] id;
    logic [31:0] mass;
    logic [31:0] px, py, pz;
    logic        clump;
    logic        known;
    force_t      exp_res;
  } body_row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [159:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_wen = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  central_gravity_force dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  logic [31:0] cx, cy, cz, cmass, kappa;
  logic [15:0] cid;
  force_t pending_forces[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  bit long_hold_req = 0;
  bit stall_free = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic force_t gravity_pull(input body_row_t b);
    force_t r;
    logic [31:0] cp[3], bp[3];
    logic signed [33:0] d;
    logic [32:0] da[3];
    logic neg[3];
    logic [127:0] s, num, fm, sq, q, mag;
    logic [63:0] u, cand;
    logic [47:0] m;
    r.id = b.id; r.fx = 0; r.fy = 0; r.fz = 0; r.applied = 0; r.coinc = 0;
    if (b.clump || b.id == cid) return r;
    r.applied = 1;
    cp[0] = cx; cp[1] = cy; cp[2] = cz;
    bp[0] = b.px; bp[1] = b.py; bp[2] = b.pz;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      d = $signed({{2{cp[i][31]}}, cp[i]}) - $signed({{2{bp[i][31]}}, bp[i]});
      neg[i] = d < 0;
      da[i] = neg[i] ? 33'(-d) : 33'(d);
      s += 128'(da[i]) * 128'(da[i]);
    end
    if (s == 0) begin
      r.coinc = 1;
      return r;
    end
    num = 128'(64'(cmass) * 64'(kappa)) * 128'(b.mass);
    fm = num / s;
    for (int i = 0; i < 3; i++) begin
      sq = (128'(da[i]) * 128'(da[i])) << 60;
      q = sq / s;
      u = 0;
      for (int k = 63; k >= 0; k--) begin
        cand = u | (64'd1 << k);
        if (128'(cand) * 128'(cand) <= q) u = cand;
      end
      mag = (fm * 128'(u)) >> 30;
      if (neg[i]) begin
        m = (mag > 128'h8000_0000_0000) ? 48'h8000_0000_0000 : mag[47:0];
        m = -m;
      end else
        m = (mag > 128'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : mag[47:0];
      if (i == 0) r.fx = m; else if (i == 1) r.fy = m; else r.fz = m;
    end
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wen <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_wen <= 0;
    case (idx)
      REG_CENTRAL_X: cx = val;
      REG_CENTRAL_Y: cy = val;
      REG_CENTRAL_Z: cz = val;
      REG_CENTRAL_M: cmass = val;
      REG_GRAVITY_K: kappa = val;
      REG_CENTRAL_ID: cid = val[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 0;
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  task automatic send_body(input body_row_t b);
    int gap;
    if (!b.known) b.exp_res = gravity_pull(b);
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {b.pz, b.py, b.px, b.mass, b.id};
    s_axis_tuser <= b.clump;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_forces.push_back(b.exp_res);
  endtask

  function automatic body_row_t rand_body(input int sizing);
    body_row_t b;
    b.id = 16'($urandom); b.mass = $urandom;
    b.clump = ($urandom_range(0, 9) == 0);
    b.known = 0;
    if (sizing == 0) begin
      b.px = $urandom; b.py = $urandom; b.pz = $urandom;
    end else begin
      b.px = cx + $urandom_range(0, 1 << sizing) - (1 << (sizing - 1));
      b.py = cy + $urandom_range(0, 1 << sizing) - (1 << (sizing - 1));
      b.pz = cz + $urandom_range(0, 1 << sizing) - (1 << (sizing - 1));
    end
    if ($urandom_range(0, 29) == 0) b.id = cid;
    if ($urandom_range(0, 29) == 0) begin
      b.px = cx; b.py = cy; b.pz = cz;
    end
    return b;
  endfunction

  // receiver side
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        force_t w;
        if (pending_forces.size() == 0) begin
          $display("result with no body pending, id %0h", m_axis_tdata[15:0]);
          errors++;
        end else begin
          w = pending_forces.pop_front();
          if (m_axis_tdata[15:0] !== w.id) report("out_id", m_axis_tdata[15:0], w.id);
          if (m_axis_tdata[63:16] !== w.fx) report("force_x", m_axis_tdata[63:16], w.fx);
          if (m_axis_tdata[111:64] !== w.fy) report("force_y", m_axis_tdata[111:64], w.fy);
          if (m_axis_tdata[159:112] !== w.fz) report("force_z", m_axis_tdata[159:112], w.fz);
          if (m_axis_tuser[0] !== w.applied) report("applied", m_axis_tuser[0], w.applied);
          if (m_axis_tuser[1] !== w.coinc) report("coincident", m_axis_tuser[1], w.coinc);
        end
      end
      if (long_hold_req) begin
        long_hold_req <= 0;
        hold_off <= 400;
        m_axis_tready <= 0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= (hold_off == 1);
      end else if (stall_free) begin
        m_axis_tready <= 1;
      end else if ($urandom_range(0, 3) == 0) begin
        hold_off <= ($urandom_range(0, 14) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("central_gravity_force test failed");
      $finish;
    end
  end

  body_row_t directed[$];

  function automatic body_row_t mk(input logic [15:0] id, input logic [31:0] mass,
                                   input logic [31:0] px, input logic [31:0] py,
                                   input logic [31:0] pz, input logic clump);
    body_row_t b;
    b.id = id; b.mass = mass; b.px = px; b.py = py; b.pz = pz; b.clump = clump;
    b.known = 0;
    return b;
  endfunction

  function automatic body_row_t mk_known(input body_row_t b, input logic [47:0] fx,
                                         input logic [47:0] fy, input logic [47:0] fz,
                                         input logic ap, input logic co);
    b.known = 1;
    b.exp_res.id = b.id; b.exp_res.fx = fx; b.exp_res.fy = fy; b.exp_res.fz = fz;
    b.exp_res.applied = ap; b.exp_res.coinc = co;
    return b;
  endfunction

  initial begin
    cx = 0; cy = 0; cz = 0; cmass = 65536; kappa = 65536; cid = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    // reset defaults: centre at origin, id 0 skipped
    directed.push_back(mk_known(mk(16'h0000, 32'h10000, 32'h10000, 0, 0, 0), 0, 0, 0, 0, 0));
    directed.push_back(mk_known(mk(16'h0005, 32'hFFFF_FFFF, 0, 0, 0, 0), 0, 0, 0, 1, 1));
    directed.push_back(mk_known(mk(16'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1),
                                0, 0, 0, 0, 0));
    directed.push_back(mk_known(mk(16'h0001, 0, 32'h10000, 32'h10000, 32'h10000, 0),
                                0, 0, 0, 1, 0));
    directed.push_back(mk(16'h0002, 32'h10000, 32'h10000, 0, 0, 0));
    directed.push_back(mk(16'h0003, 32'h10000, 0, 32'hFFFF_0000, 0, 0));
    directed.push_back(mk(16'h0004, 32'hFFFF_FFFF, 0, 0, 32'h1, 0));
    directed.push_back(mk(16'h0006, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 0));
    directed.push_back(mk(16'h0007, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    directed.push_back(mk(16'h0008, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 0));
    directed.push_back(mk(16'hAAAA, 32'h5555_5555, 32'h0001_2345, 32'hFFF0_0000, 32'h3, 0));
    foreach (directed[i]) send_body(directed[i]);
    wait_drained();

    write_reg(REG_CENTRAL_X, 32'h8000_0000);
    write_reg(REG_CENTRAL_Y, 32'h7FFF_FFFF);
    write_reg(REG_CENTRAL_Z, 32'h0);
    write_reg(REG_CENTRAL_M, 32'hFFFF_FFFF);
    write_reg(REG_GRAVITY_K, 32'hFFFF_FFFF);
    write_reg(REG_CENTRAL_ID, 32'h0000_FFFF);
    write_reg(REG_UNUSED, 32'h1234_5678);
    send_body(mk(16'h0010, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    send_body(mk(16'h0011, 32'hFFFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFF, 0, 0));
    send_body(mk_known(mk(16'hFFFF, 32'h1, 0, 0, 0, 0), 0, 0, 0, 0, 0));
    send_body(mk_known(mk(16'h0012, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0), 0, 0, 0, 1, 1));
    wait_drained();
    write_reg(REG_GRAVITY_K, 32'h0);
    send_body(mk_known(mk(16'h0013, 32'hFFFF_FFFF, 0, 0, 0, 0), 0, 0, 0, 1, 0));
    wait_drained();

    for (int phase = 0; phase < 5; phase++) begin
      write_reg(REG_CENTRAL_X, $urandom);
      write_reg(REG_CENTRAL_Y, $urandom);
      write_reg(REG_CENTRAL_Z, $urandom);
      write_reg(REG_CENTRAL_M, (phase == 4) ? 32'h0 : $urandom);
      write_reg(REG_GRAVITY_K, (phase == 3) ? 32'hFFFF_FFFF : $urandom);
      write_reg(REG_CENTRAL_ID, $urandom);
      stall_free = (phase == 2);
      if (phase == 1) long_hold_req = 1;
      for (int n = 0; n < 145; n++) begin
        int sz;
        sz = $urandom_range(0, 4);
        send_body(rand_body(sz == 0 ? 0 : $urandom_range(1, 31)));
      end
      stall_free = 0;
      wait_drained();
    end

    if (errors == 0)
      $display("central_gravity_force test passed");
    else
      $display("central_gravity_force test failed");
    $finish;
  end
endmodule

// ----- files.f -----
design/cgf_pkg.sv
design/cgf_divider.sv
design/cgf_isqrt.sv
design/cgf_scale.sv
design/central_gravity_force.sv
tb/tb_central_gravity_force.sv
